FILE: design/greedy_word_wrap_line_breaker_macros.svh
// Assertion macros used by the checker of the line breaker.
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_MACROS_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GWW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/gwwlb_pkg.sv
package gwwlb_pkg;

   localparam logic [7:0] NL_BYTE = 8'h0A;
   localparam logic [7:0] SP_BYTE = 8'h20;

   localparam logic [9:0] LINE_WIDTH_RESET = 10'd40;

   localparam int BUFFER_BYTES_DEFAULT = 65536;
   localparam int LINE_SLOTS_DEFAULT   = 4096;

   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   typedef struct packed {
      logic [15:0] line_start;
      logic [11:0] line_number;
      logic [12:0] line_total;
      logic        is_summary;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

FILE: design/gwwlb_core.sv
module gwwlb_core #(
   parameter int BUFFER_BYTES = gwwlb_pkg::BUFFER_BYTES_DEFAULT,
   parameter int LINE_SLOTS   = gwwlb_pkg::LINE_SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           ch,
   input  logic                 text_end,
   input  logic                 csr_write_enable,
   input  logic [9:0]           csr_write_data,
   output gwwlb_pkg::push_type  push
);

   localparam int LINES_BITS = $clog2(LINE_SLOTS + 1);
   localparam int LINES_W    = (LINES_BITS > 13) ? LINES_BITS : 13;

   logic [9:0]         line_width_ff, line_width_in;
   logic [15:0]        byte_pos_ff, byte_pos_in;
   logic [15:0]        column_ff, column_in;
   logic               space_seen_ff, space_seen_in;
   logic [15:0]        space_pos_ff, space_pos_in;
   logic [15:0]        line_start_ff, line_start_in;
   logic [LINES_W-1:0] lines_ff, lines_in;

   logic               in_buf;
   logic               active;
   logic               is_nl;
   logic               is_sp;
   logic               seen_nx;
   logic [15:0]        pos_nx;
   logic [15:0]        col_nx;
   logic [15:0]        next_pos;
   logic               wrap;
   logic [15:0]        wrap_pos;
   logic               do_break;
   logic [15:0]        brk_pos;
   logic [LINES_W-1:0] lines_adv;
   gwwlb_pkg::rsp_type brk_rsp;
   gwwlb_pkg::rsp_type sum_rsp;

   always_comb begin
      in_buf   = ((32'(byte_pos_ff) + 32'd1) < 32'(BUFFER_BYTES)) && (byte_pos_ff != 16'hFFFF);
      active   = in_buf && (32'(lines_ff) < 32'(LINE_SLOTS));
      is_nl    = (ch == gwwlb_pkg::NL_BYTE);
      is_sp    = (ch == gwwlb_pkg::SP_BYTE);
      next_pos = byte_pos_ff + 16'd1;
      seen_nx  = space_seen_ff || is_sp;
      pos_nx   = is_sp ? byte_pos_ff : space_pos_ff;
      col_nx   = column_ff + 16'd1;
      wrap     = !is_nl && (col_nx >= {6'd0, line_width_ff});
      wrap_pos = (seen_nx && (pos_nx > line_start_ff)) ? (pos_nx + 16'd1) : next_pos;
      do_break = active && (is_nl || wrap);
      brk_pos  = is_nl ? next_pos : wrap_pos;
      lines_adv = lines_ff + LINES_W'(do_break);
   end

   always_comb begin
      line_width_in = line_width_ff;
      byte_pos_in   = byte_pos_ff;
      column_in     = column_ff;
      space_seen_in = space_seen_ff;
      space_pos_in  = space_pos_ff;
      line_start_in = line_start_ff;
      lines_in      = lines_ff;
      if (csr_write_enable) begin
         line_width_in = csr_write_data;
      end
      if (accept) begin
         if (active) begin
            if (is_nl) begin
               column_in     = 16'd0;
               space_seen_in = 1'b0;
               line_start_in = next_pos;
            end else begin
               space_seen_in = seen_nx;
               space_pos_in  = pos_nx;
               column_in     = col_nx;
               if (wrap) begin
                  column_in     = next_pos - wrap_pos;
                  line_start_in = wrap_pos;
                  space_seen_in = 1'b0;
               end
            end
            lines_in = lines_adv;
         end
         if (in_buf) begin
            byte_pos_in = next_pos;
         end
         if (text_end) begin
            byte_pos_in   = 16'd0;
            column_in     = 16'd0;
            space_seen_in = 1'b0;
            space_pos_in  = 16'd0;
            line_start_in = 16'd0;
            lines_in      = LINES_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= gwwlb_pkg::LINE_WIDTH_RESET;
         byte_pos_ff   <= 16'd0;
         column_ff     <= 16'd0;
         space_seen_ff <= 1'b0;
         space_pos_ff  <= 16'd0;
         line_start_ff <= 16'd0;
         lines_ff      <= LINES_W'(1);
      end else begin
         line_width_ff <= line_width_in;
         byte_pos_ff   <= byte_pos_in;
         column_ff     <= column_in;
         space_seen_ff <= space_seen_in;
         space_pos_ff  <= space_pos_in;
         line_start_ff <= line_start_in;
         lines_ff      <= lines_in;
      end
   end

   always_comb begin
      brk_rsp.line_start  = brk_pos;
      brk_rsp.line_number = lines_ff[11:0];
      brk_rsp.line_total  = 13'd0;
      brk_rsp.is_summary  = 1'b0;
      brk_rsp.last        = !text_end;

      sum_rsp.line_start  = 16'd0;
      sum_rsp.line_number = 12'd0;
      sum_rsp.line_total  = lines_adv[12:0];
      sum_rsp.is_summary  = 1'b1;
      sum_rsp.last        = 1'b1;

      push.count  = accept ? ({1'b0, do_break} + {1'b0, text_end}) : 2'd0;
      push.first  = do_break ? brk_rsp : sum_rsp;
      push.second = sum_rsp;
   end

endmodule

FILE: design/gwwlb_fifo.sv
module gwwlb_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gwwlb_pkg::push_type                  push,
   input  logic                                 pop,
   output logic                                 full_for_two,
   output logic                                 not_empty,
   output gwwlb_pkg::rsp_type                   head
);

   gwwlb_pkg::rsp_type                  entry_ff [gwwlb_pkg::RQ_DEPTH];
   logic [gwwlb_pkg::RQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [gwwlb_pkg::RQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [gwwlb_pkg::RQ_CNT_W-1:0]      count_ff, count_in;
   logic [gwwlb_pkg::RQ_PTR_W-1:0]      wr_ptr_plus;

   always_comb begin
      wr_ptr_plus = wr_ptr_ff + gwwlb_pkg::RQ_PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + gwwlb_pkg::RQ_PTR_W'(push.count);
      rd_ptr_in   = rd_ptr_ff + gwwlb_pkg::RQ_PTR_W'(pop);
      count_in    = count_ff + gwwlb_pkg::RQ_CNT_W'(push.count)
                  - gwwlb_pkg::RQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_plus] <= push.second;
      end
   end

   assign full_for_two = (count_ff > gwwlb_pkg::RQ_CNT_W'(gwwlb_pkg::RQ_DEPTH - 2));
   assign not_empty    = (count_ff != '0);
   assign head         = entry_ff[rd_ptr_ff];

endmodule

FILE: design/greedy_word_wrap_line_breaker.sv
// Results of a beat are written into the result queue when the beat is taken and offered from its head.
// Throughput: one input beat per cycle while each byte yields at most one result and rsp_stall
// is low; a byte that yields two results (a break plus the summary) is drained through
// the single read port of the four-entry result queue, which stalls the input as it fills.
// Reset: synchronous, active high; line width returns to 40, the scan restarts at
// position 0 with one line counted, and the result queue empties.
module greedy_word_wrap_line_breaker #(
   parameter int BUFFER_BYTES = gwwlb_pkg::BUFFER_BYTES_DEFAULT,
   parameter int LINE_SLOTS   = gwwlb_pkg::LINE_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_text_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_line_start,
   output logic [11:0] rsp_line_number,
   output logic [12:0] rsp_line_total,
   output logic        rsp_is_summary,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [9:0]  csr_write_data
);

   logic                accept;
   logic                full_for_two;
   logic                not_empty;
   gwwlb_pkg::push_type push;
   gwwlb_pkg::rsp_type  head;

   assign req_stall = full_for_two;
   assign accept    = req_valid && !full_for_two;

   gwwlb_core #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .LINE_SLOTS   (LINE_SLOTS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .ch               (req_ch),
      .text_end         (req_text_end),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push)
   );

   gwwlb_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (not_empty && !rsp_stall),
      .full_for_two (full_for_two),
      .not_empty    (not_empty),
      .head         (head)
   );

   assign rsp_valid       = not_empty;
   assign rsp_line_start  = head.line_start;
   assign rsp_line_number = head.line_number;
   assign rsp_line_total  = head.line_total;
   assign rsp_is_summary  = head.is_summary;
   assign rsp_last        = head.last;

endmodule

FILE: design/gwwlb_checker.sv
`include "greedy_word_wrap_line_breaker_macros.svh"

module gwwlb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_line_start,
   input logic [11:0] rsp_line_number,
   input logic [12:0] rsp_line_total,
   input logic        rsp_is_summary,
   input logic        rsp_last
);

   // A stalled result beat stays offered, and all its fields but the line number stay unchanged.
   `GWW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_line_start) && $stable(rsp_line_total) && $stable(rsp_is_summary) && $stable(rsp_last), "result beat changed while stalled")

   // The summary closes the results of its byte and carries only the count.
   `GWW_ASSERT_NOW(a_sum_shape, rsp_valid && rsp_is_summary, rsp_last && (rsp_line_start == 16'd0) && (rsp_line_number == 12'd0) && (rsp_line_total != 13'd0), "malformed summary beat")

   // A line start always follows at least one byte and carries no count.
   `GWW_ASSERT_NOW(a_brk_shape, rsp_valid && !rsp_is_summary, (rsp_line_start != 16'd0) && (rsp_line_total == 13'd0), "malformed line start beat")

   // A line start that is not last is always followed by its summary.
   `GWW_ASSERT_NEXT(a_brk_then_sum, rsp_valid && !rsp_stall && !rsp_is_summary && !rsp_last, !rsp_valid || rsp_is_summary, "break without last was not followed by its summary")

endmodule

bind greedy_word_wrap_line_breaker gwwlb_checker u_gwwlb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_line_start  (rsp_line_start),
   .rsp_line_number (rsp_line_number),
   .rsp_line_total  (rsp_line_total),
   .rsp_is_summary  (rsp_is_summary),
   .rsp_last        (rsp_last)
);
